### sv/psie_pkg.sv
`timescale 1ns / 1ps

package psie_pkg;

    // Command codes of the input transaction
    localparam logic [2:0] CMD_WRITE = 3'd0;
    localparam logic [2:0] CMD_NEXT  = 3'd1;
    localparam logic [2:0] CMD_PREV  = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_COUNT = 3'd4;

    localparam int CMD_W   = 3;
    localparam int INDEX_W = 4;
    localparam int VALUE_W = 8;
    localparam int LEN_W   = 5;
    localparam int POS_W   = 4;
    localparam int INV_W   = 7;
    localparam int LEN_RESET = 16;
    localparam int RESULT_CAP = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_FIND_RD,
        S_FIND_CMP,
        S_SWAP2,
        S_REV_RD,
        S_REV_W1,
        S_REV_W2,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_INV,
        S_INV_TAIL,
        S_INV_OUT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_ACCEPT,
        DP_SCAN_RD,
        DP_SCAN_CMP,
        DP_FIND_RD,
        DP_FIND_CMP,
        DP_SWAP2,
        DP_REV_RD,
        DP_REV_W1,
        DP_REV_W2,
        DP_EMIT_RD,
        DP_EMIT_OUT,
        DP_INV_ISSUE,
        DP_INV_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic short_len;
        logic hit;
        logic i_zero;
        logic found;
        logic lo_lt_hi;
        logic k_last;
        logic inv_last;
    } t_dp_stat;

endpackage

### sv/psie_ram.sv
`timescale 1ns / 1ps

module psie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

### sv/psie_dp.sv
`timescale 1ns / 1ps

module psie_dp #(
    parameter int MAX_LEN = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  psie_pkg::t_dp_cmd                 i_cmd,
    output psie_pkg::t_dp_stat                o_stat,
    input  logic [psie_pkg::CMD_W-1:0]        i_command,
    input  logic [psie_pkg::INDEX_W-1:0]      i_index,
    input  logic [psie_pkg::VALUE_W-1:0]      i_value,
    input  logic                              i_cfg_wr_en,
    input  logic [psie_pkg::LEN_W-1:0]        i_cfg_wr_data,
    output logic [psie_pkg::POS_W-1:0]        o_position,
    output logic [psie_pkg::VALUE_W-1:0]      o_element,
    output logic                              o_last,
    output logic                              o_wrapped,
    output logic [psie_pkg::INV_W-1:0]        o_inversions,
    output logic                              o_odd
);

    localparam int IW  = $clog2(MAX_LEN);
    localparam int CAP = (MAX_LEN < psie_pkg::RESULT_CAP) ? MAX_LEN : psie_pkg::RESULT_CAP;
    localparam int NW  = $clog2(CAP + 1);
    localparam int VW  = psie_pkg::VALUE_W;

    logic [psie_pkg::LEN_W-1:0] r_len;
    logic [IW-1:0]              r_i, r_j, r_lo, r_hi, r_k;
    logic [VW-1:0]              r_ai;
    logic                       r_up, r_wrap, r_pv;
    logic [psie_pkg::INV_W-1:0] r_count;

    logic [NW-1:0]   w_n;
    logic [IW-1:0]   w_nm1, w_nm2;
    logic [IW-1:0]   w_ra0, w_ra1, w_wa;
    logic [VW-1:0]   w_wd, w_d0, w_d1;
    logic            w_we;
    logic [IW+3:0]   w_idx_wide, w_k_wide;
    logic            w_idx_ok, w_is_write;

    // Clamp the programmed length to 1..CAP
    always_comb begin
        if (r_len == '0) begin
            w_n = NW'(1);
        end else if (32'(r_len) > CAP) begin
            w_n = NW'(CAP);
        end else begin
            w_n = NW'(r_len);
        end
    end

    assign w_nm1 = IW'(32'(w_n) - 32'd1);
    assign w_nm2 = IW'(32'(w_n) - 32'd2);

    assign w_idx_wide = {{IW{1'b0}}, i_index};
    assign w_k_wide   = {4'b0000, r_k};
    assign w_idx_ok   = 32'(i_index) < MAX_LEN;
    assign w_is_write = (i_command == psie_pkg::CMD_WRITE);

    psie_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_waddr  (w_wa),
        .i_wdata  (w_wd),
        .i_raddr0 (w_ra0),
        .i_raddr1 (w_ra1),
        .o_rdata0 (w_d0),
        .o_rdata1 (w_d1)
    );

    // Memory port steering
    always_comb begin
        w_ra0 = '0;
        w_ra1 = '0;
        w_we  = 1'b0;
        w_wa  = '0;
        w_wd  = '0;
        unique case (i_cmd.op)
            psie_pkg::DP_ACCEPT: begin
                w_we = w_is_write && w_idx_ok;
                w_wa = w_idx_wide[IW-1:0];
                w_wd = i_value;
            end
            psie_pkg::DP_SCAN_RD: begin
                w_ra0 = r_i;
                w_ra1 = r_i + IW'(1);
            end
            psie_pkg::DP_FIND_RD: begin
                w_ra0 = r_j;
            end
            psie_pkg::DP_FIND_CMP: begin
                w_we = o_stat.found;
                w_wa = r_i;
                w_wd = w_d0;
            end
            psie_pkg::DP_SWAP2: begin
                w_we = 1'b1;
                w_wa = r_j;
                w_wd = r_ai;
            end
            psie_pkg::DP_REV_RD: begin
                w_ra0 = r_lo;
                w_ra1 = r_hi;
            end
            psie_pkg::DP_REV_W1: begin
                w_we = 1'b1;
                w_wa = r_lo;
                w_wd = w_d1;
            end
            psie_pkg::DP_REV_W2: begin
                w_we = 1'b1;
                w_wa = r_hi;
                w_wd = r_ai;
            end
            psie_pkg::DP_EMIT_RD: begin
                w_ra0 = r_k;
            end
            psie_pkg::DP_EMIT_OUT: begin
                w_ra0 = r_k + IW'(1);
            end
            psie_pkg::DP_INV_ISSUE: begin
                w_ra0 = r_i;
                w_ra1 = r_j;
            end
            default: begin
            end
        endcase
    end

    // Status toward the controller
    always_comb begin
        o_stat.short_len = (w_n < NW'(2));
        o_stat.hit       = r_up ? (w_d0 < w_d1) : (w_d0 > w_d1);
        o_stat.i_zero    = (r_i == '0);
        o_stat.found     = r_up ? (w_d0 > r_ai) : (w_d0 < r_ai);
        o_stat.lo_lt_hi  = (r_lo < r_hi);
        o_stat.k_last    = (r_k == w_nm1);
        o_stat.inv_last  = (r_i == w_nm2) && (r_j == w_nm1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= psie_pkg::LEN_W'(psie_pkg::LEN_RESET);
            r_pv  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_len <= i_cfg_wr_data;
            end
            r_pv <= (i_cmd.op == psie_pkg::DP_INV_ISSUE);
        end
    end

    always_ff @(posedge i_clk) begin
        // Accumulate the pair compared in the previous cycle
        if (r_pv && (w_d0 > w_d1)) begin
            r_count <= r_count + psie_pkg::INV_W'(1);
        end
        unique case (i_cmd.op)
            psie_pkg::DP_ACCEPT: begin
                r_up    <= (i_command == psie_pkg::CMD_NEXT);
                r_wrap  <= ((i_command == psie_pkg::CMD_NEXT) ||
                            (i_command == psie_pkg::CMD_PREV)) && o_stat.short_len;
                r_k     <= '0;
                r_count <= '0;
                if (i_command == psie_pkg::CMD_COUNT) begin
                    r_i <= '0;
                    r_j <= IW'(1);
                end else begin
                    r_i <= w_nm2;
                    r_j <= w_nm1;
                end
            end
            psie_pkg::DP_SCAN_CMP: begin
                if (o_stat.hit) begin
                    r_ai <= w_d0;
                    r_j  <= w_nm1;
                end else if (o_stat.i_zero) begin
                    r_wrap <= 1'b1;
                    r_lo   <= '0;
                    r_hi   <= w_nm1;
                end else begin
                    r_i <= r_i - IW'(1);
                end
            end
            psie_pkg::DP_FIND_CMP: begin
                if (!o_stat.found) begin
                    r_j <= r_j - IW'(1);
                end
            end
            psie_pkg::DP_SWAP2: begin
                r_lo <= r_i + IW'(1);
                r_hi <= w_nm1;
            end
            psie_pkg::DP_REV_W1: begin
                r_ai <= w_d0;
            end
            psie_pkg::DP_REV_W2: begin
                r_lo <= r_lo + IW'(1);
                r_hi <= r_hi - IW'(1);
            end
            psie_pkg::DP_EMIT_OUT: begin
                r_k <= r_k + IW'(1);
            end
            psie_pkg::DP_INV_ISSUE: begin
                if (r_j == w_nm1) begin
                    r_i <= r_i + IW'(1);
                    r_j <= r_i + IW'(2);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields
    always_comb begin
        o_position   = '0;
        o_element    = '0;
        o_last       = 1'b0;
        o_wrapped    = 1'b0;
        o_inversions = '0;
        o_odd        = 1'b0;
        unique case (i_cmd.op)
            psie_pkg::DP_EMIT_OUT: begin
                o_position = w_k_wide[psie_pkg::POS_W-1:0];
                o_element  = w_d0;
                o_last     = o_stat.k_last;
                o_wrapped  = r_wrap;
            end
            psie_pkg::DP_INV_OUT: begin
                o_last       = 1'b1;
                o_inversions = r_count;
                o_odd        = r_count[0];
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/psie_ctrl.sv
`timescale 1ns / 1ps

module psie_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [psie_pkg::CMD_W-1:0] i_command,
    input  psie_pkg::t_dp_stat         i_stat,
    output psie_pkg::t_dp_cmd          o_cmd,
    output logic                       o_strobe
);

    psie_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psie_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd.op  = psie_pkg::DP_NOP;
        busy      = 1'b1;
        o_strobe  = 1'b0;
        unique case (r_state)
            psie_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.op = psie_pkg::DP_ACCEPT;
                    case (i_command)
                        psie_pkg::CMD_NEXT, psie_pkg::CMD_PREV: begin
                            n_state = i_stat.short_len ? psie_pkg::S_EMIT_RD
                                                       : psie_pkg::S_SCAN_RD;
                        end
                        psie_pkg::CMD_READ: begin
                            n_state = psie_pkg::S_EMIT_RD;
                        end
                        psie_pkg::CMD_COUNT: begin
                            n_state = i_stat.short_len ? psie_pkg::S_INV_OUT
                                                       : psie_pkg::S_INV;
                        end
                        default: begin
                            n_state = psie_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            psie_pkg::S_SCAN_RD: begin
                o_cmd.op = psie_pkg::DP_SCAN_RD;
                n_state  = psie_pkg::S_SCAN_CMP;
            end
            psie_pkg::S_SCAN_CMP: begin
                o_cmd.op = psie_pkg::DP_SCAN_CMP;
                if (i_stat.hit) begin
                    n_state = psie_pkg::S_FIND_RD;
                end else if (i_stat.i_zero) begin
                    n_state = psie_pkg::S_REV_RD;
                end else begin
                    n_state = psie_pkg::S_SCAN_RD;
                end
            end
            psie_pkg::S_FIND_RD: begin
                o_cmd.op = psie_pkg::DP_FIND_RD;
                n_state  = psie_pkg::S_FIND_CMP;
            end
            psie_pkg::S_FIND_CMP: begin
                o_cmd.op = psie_pkg::DP_FIND_CMP;
                n_state  = i_stat.found ? psie_pkg::S_SWAP2 : psie_pkg::S_FIND_RD;
            end
            psie_pkg::S_SWAP2: begin
                o_cmd.op = psie_pkg::DP_SWAP2;
                n_state  = psie_pkg::S_REV_RD;
            end
            psie_pkg::S_REV_RD: begin
                o_cmd.op = psie_pkg::DP_REV_RD;
                n_state  = i_stat.lo_lt_hi ? psie_pkg::S_REV_W1 : psie_pkg::S_EMIT_RD;
            end
            psie_pkg::S_REV_W1: begin
                o_cmd.op = psie_pkg::DP_REV_W1;
                n_state  = psie_pkg::S_REV_W2;
            end
            psie_pkg::S_REV_W2: begin
                o_cmd.op = psie_pkg::DP_REV_W2;
                n_state  = psie_pkg::S_REV_RD;
            end
            psie_pkg::S_EMIT_RD: begin
                o_cmd.op = psie_pkg::DP_EMIT_RD;
                n_state  = psie_pkg::S_EMIT_OUT;
            end
            psie_pkg::S_EMIT_OUT: begin
                o_cmd.op = psie_pkg::DP_EMIT_OUT;
                o_strobe = 1'b1;
                if (i_stat.k_last) begin
                    n_state = psie_pkg::S_IDLE;
                end
            end
            psie_pkg::S_INV: begin
                o_cmd.op = psie_pkg::DP_INV_ISSUE;
                if (i_stat.inv_last) begin
                    n_state = psie_pkg::S_INV_TAIL;
                end
            end
            psie_pkg::S_INV_TAIL: begin
                n_state = psie_pkg::S_INV_OUT;
            end
            psie_pkg::S_INV_OUT: begin
                o_cmd.op = psie_pkg::DP_INV_OUT;
                o_strobe = 1'b1;
                n_state  = psie_pkg::S_IDLE;
            end
            default: begin
                n_state = psie_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/permutation_step_inversion_engine.sv
`timescale 1ns / 1ps
// A write is done on acceptance; read out emits n results, one per cycle;
// next/previous scan pairs, probe for the successor and swap and reverse the suffix,
// then emit n results, one per cycle; count compares every pair once,
// one pair compare per cycle on the two memory read ports. One transaction at a time.
// Results appear for one cycle under o_strobe; the receiver cannot stall them.
// Reset (synchronous, active low) idles the sequencer and sets length_in_use to 16.

module permutation_step_inversion_engine #(
    parameter int MAX_LEN = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command transaction: taken when start is high and busy is low
    input  logic                           start,
    output logic                           busy,
    input  logic [psie_pkg::CMD_W-1:0]     i_command,
    input  logic [psie_pkg::INDEX_W-1:0]   i_index,
    input  logic [psie_pkg::VALUE_W-1:0]   i_value,
    // length_in_use register
    input  logic                           i_cfg_wr_en,
    input  logic [psie_pkg::LEN_W-1:0]     i_cfg_wr_data,
    // result transaction, one per strobe cycle
    output logic                           o_strobe,
    output logic [psie_pkg::POS_W-1:0]     o_position,
    output logic [psie_pkg::VALUE_W-1:0]   o_element,
    output logic                           o_last,
    output logic                           o_wrapped,
    output logic [psie_pkg::INV_W-1:0]     o_inversions,
    output logic                           o_odd
);

    // Controller sequences the scan, successor search, suffix reversal,
    // emit and pair count; the datapath owns the element memory, the
    // index registers and the inversion counter.
    psie_pkg::t_dp_cmd  w_cmd;
    psie_pkg::t_dp_stat w_stat;

    psie_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_strobe  (o_strobe)
    );

    psie_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_position    (o_position),
        .o_element     (o_element),
        .o_last        (o_last),
        .o_wrapped     (o_wrapped),
        .o_inversions  (o_inversions),
        .o_odd         (o_odd)
    );

endmodule

### test/tb_permutation_step_inversion_engine.sv
`timescale 1ns / 1ps

module tb_permutation_step_inversion_engine;

    localparam int LIST_DEPTH    = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Slowest commands are a count over 16 elements and a full step;
    // roughly 210 transactions with gaps, taken many times over.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    // One emitted element of an arrangement, or one inversion count.
    typedef struct {
        bit [psie_pkg::POS_W-1:0]   position;
        bit [psie_pkg::VALUE_W-1:0] element;
        bit                         last;
        bit                         wrapped;
        bit [psie_pkg::INV_W-1:0]   inversions;
        bit                         odd;
    } perm_result_t;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [psie_pkg::CMD_W-1:0]     i_command = '0;
    logic [psie_pkg::INDEX_W-1:0]   i_index = '0;
    logic [psie_pkg::VALUE_W-1:0]   i_value = '0;
    logic                           i_cfg_wr_en = 1'b0;
    logic [psie_pkg::LEN_W-1:0]     i_cfg_wr_data = '0;
    logic                           o_strobe;
    logic [psie_pkg::POS_W-1:0]     o_position;
    logic [psie_pkg::VALUE_W-1:0]   o_element;
    logic                           o_last;
    logic                           o_wrapped;
    logic [psie_pkg::INV_W-1:0]     o_inversions;
    logic                           o_odd;

    // Shadow copy of the element store and the length register
    bit [psie_pkg::VALUE_W-1:0] shadow_array [LIST_DEPTH];
    bit [psie_pkg::LEN_W-1:0]   shadow_len;
    perm_result_t               expected_elements [$];

    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned commands_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned wraps_seen    = 0;
    int unsigned counts_seen   = 0;
    bit          no_gaps       = 1'b0;

    permutation_step_inversion_engine #(
        .MAX_LEN(LIST_DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_index       (i_index),
        .i_value       (i_value),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_strobe      (o_strobe),
        .o_position    (o_position),
        .o_element     (o_element),
        .o_last        (o_last),
        .o_wrapped     (o_wrapped),
        .o_inversions  (o_inversions),
        .o_odd         (o_odd)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung sequencer or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_elements.size());
            $display("[permutation_step_inversion_engine] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Clamp the register: 0 acts as 1, anything past the store acts as its depth.
    function automatic int active_length();
        int n;
        n = shadow_len;
        if (n < 1) n = 1;
        if (n > LIST_DEPTH) n = LIST_DEPTH;
        return n;
    endfunction

    function automatic void reverse_run(int lo, int hi);
        bit [psie_pkg::VALUE_W-1:0] t;
        while (lo < hi) begin
            t = shadow_array[lo];
            shadow_array[lo] = shadow_array[hi];
            shadow_array[hi] = t;
            lo++;
            hi--;
        end
    endfunction

    // Move to the next (up) or previous arrangement in multiset order.
    // Return 1 when the order wrapped around.
    function automatic bit step_arrangement(int n, bit up);
        int i;
        int j;
        bit found;
        bit [psie_pkg::VALUE_W-1:0] t;
        if (n < 2) return 1'b1;
        found = 1'b0;
        i = n - 1;
        while (i > 0) begin
            i--;
            if (up ? (shadow_array[i] < shadow_array[i+1])
                   : (shadow_array[i] > shadow_array[i+1])) begin
                found = 1'b1;
                break;
            end
        end
        if (!found) begin
            // Last order steps to first (or first to last): reverse everything
            reverse_run(0, n - 1);
            return 1'b1;
        end
        j = n - 1;
        while (up ? !(shadow_array[j] > shadow_array[i])
                  : !(shadow_array[j] < shadow_array[i]))
            j--;
        t = shadow_array[i];
        shadow_array[i] = shadow_array[j];
        shadow_array[j] = t;
        reverse_run(i + 1, n - 1);
        return 1'b0;
    endfunction

    function automatic void queue_arrangement(int n, bit wrap);
        perm_result_t r;
        for (int k = 0; k < n; k++) begin
            r.position   = k[psie_pkg::POS_W-1:0];
            r.element    = shadow_array[k];
            r.last       = (k == n - 1);
            r.wrapped    = wrap;
            r.inversions = '0;
            r.odd        = 1'b0;
            expected_elements.push_back(r);
        end
    endfunction

    // Update the shadow state for one accepted transaction and queue its results.
    function automatic void predict_command(logic [psie_pkg::CMD_W-1:0] cmd,
                                            logic [psie_pkg::INDEX_W-1:0] idx,
                                            logic [psie_pkg::VALUE_W-1:0] val);
        int n;
        int pairs;
        bit wrap;
        perm_result_t r;
        n = active_length();
        case (cmd)
            psie_pkg::CMD_WRITE: begin
                if (idx < LIST_DEPTH) shadow_array[idx] = val;
            end
            psie_pkg::CMD_NEXT, psie_pkg::CMD_PREV: begin
                wrap = step_arrangement(n, cmd == psie_pkg::CMD_NEXT);
                if (wrap) wraps_seen++;
                queue_arrangement(n, wrap);
            end
            psie_pkg::CMD_READ: begin
                queue_arrangement(n, 1'b0);
            end
            psie_pkg::CMD_COUNT: begin
                pairs = 0;
                for (int i = 0; i + 1 < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (shadow_array[i] > shadow_array[j]) pairs++;
                r.position   = '0;
                r.element    = '0;
                r.last       = 1'b1;
                r.wrapped    = 1'b0;
                r.inversions = pairs[psie_pkg::INV_W-1:0];
                r.odd        = pairs[0];
                expected_elements.push_back(r);
                counts_seen++;
            end
            default: ;  // unused codes emit nothing
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        perm_result_t want;
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (expected_elements.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result: pos %0d elem %0d last %0b wrap %0b inv %0d odd %0b",
                             o_position, o_element, o_last, o_wrapped, o_inversions, o_odd);
            end else begin
                want = expected_elements.pop_front();
                if (o_position !== want.position || o_element !== want.element ||
                    o_last !== want.last || o_wrapped !== want.wrapped ||
                    o_inversions !== want.inversions || o_odd !== want.odd) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("mismatch exp: pos %0d elem %0d last %0b wrap %0b inv %0d odd %0b",
                                 want.position, want.element, want.last, want.wrapped,
                                 want.inversions, want.odd);
                        $display("         got: pos %0d elem %0d last %0b wrap %0b inv %0d odd %0b",
                                 o_position, o_element, o_last, o_wrapped,
                                 o_inversions, o_odd);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one transaction and hold it until the block takes it. Start stays
    // high afterwards so the next call can follow back to back; call
    // drain_results before anything that waits.
    task automatic issue_command(input logic [psie_pkg::CMD_W-1:0] cmd,
                                 input logic [psie_pkg::INDEX_W-1:0] idx,
                                 input logic [psie_pkg::VALUE_W-1:0] val);
        while (!no_gaps && $urandom_range(0, 99) < 19) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_index   <= idx;
        i_value   <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(cmd, idx, val);
        commands_sent++;
    endtask

    // Drop start, wait for every queued result, then let the sequencer settle.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_elements.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write length_in_use; only ever called with the block idle.
    task automatic set_length(input logic [psie_pkg::LEN_W-1:0] len);
        drain_results();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_len = len;
    endtask

    task automatic issue_random_step(input logic [psie_pkg::CMD_W-1:0] cmd);
        issue_command(cmd, psie_pkg::INDEX_W'($urandom_range(0, 15)),
                      psie_pkg::VALUE_W'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill all 16 entries in strictly descending order (255 down to 0) at the
    // reset length, so the last arrangement is loaded: count gives the maximum
    // 120, next wraps to ascending and previous wraps back.
    task automatic test_full_length_wrap();
        for (int k = 0; k < LIST_DEPTH; k++)
            issue_command(psie_pkg::CMD_WRITE, psie_pkg::INDEX_W'(k),
                          psie_pkg::VALUE_W'(255 - 17 * k));
        issue_random_step(psie_pkg::CMD_COUNT);
        issue_random_step(psie_pkg::CMD_NEXT);
        issue_random_step(psie_pkg::CMD_PREV);
        issue_random_step(psie_pkg::CMD_READ);
    endtask

    // Single element, zero and oversize lengths, a two-element swap, unused codes.
    task automatic test_length_edges();
        set_length(5'd1);
        issue_random_step(psie_pkg::CMD_NEXT);
        issue_random_step(psie_pkg::CMD_PREV);
        set_length(5'd0);
        issue_random_step(psie_pkg::CMD_COUNT);
        set_length(5'd31);
        issue_random_step(psie_pkg::CMD_READ);
        set_length(5'd2);
        issue_random_step(psie_pkg::CMD_NEXT);
        issue_command(3'd5, 4'd15, 8'hff);
        issue_command(3'd7, 4'd0, 8'h00);
    endtask

    // Repeated values: 7 7 9 has three distinct orders, then wraps.
    task automatic test_repeated_values();
        set_length(5'd3);
        issue_command(psie_pkg::CMD_WRITE, 4'd0, 8'd7);
        issue_command(psie_pkg::CMD_WRITE, 4'd1, 8'd7);
        issue_command(psie_pkg::CMD_WRITE, 4'd2, 8'd9);
        repeat (3) issue_random_step(psie_pkg::CMD_NEXT);
        issue_random_step(psie_pkg::CMD_PREV);
    endtask

    // Mostly runs of steps in one direction over small lengths, so wrap-around
    // comes often; writes with a narrow value range create repeated values.
    task automatic test_random_traffic(input int unsigned total);
        int unsigned phase_len [7];
        int unsigned per_phase;
        int unsigned done;
        int unsigned pick;
        int unsigned burst;
        logic [psie_pkg::CMD_W-1:0] dir;
        phase_len = '{3, 4, 2, 0, 5, 16, 0};
        phase_len[3] = $urandom_range(0, 31);
        phase_len[6] = $urandom_range(1, 6);
        per_phase = total / 7;
        for (int p = 0; p < 7; p++) begin
            set_length(psie_pkg::LEN_W'(phase_len[p]));
            no_gaps = (p == 2);
            done = 0;
            while (done < per_phase) begin
                pick = $urandom_range(0, 99);
                if (pick < 28) begin
                    issue_command(psie_pkg::CMD_WRITE,
                                  psie_pkg::INDEX_W'($urandom_range(0, 15)),
                                  $urandom_range(0, 1)
                                      ? psie_pkg::VALUE_W'($urandom_range(0, 3))
                                      : psie_pkg::VALUE_W'($urandom_range(0, 255)));
                    done++;
                end else if (pick < 70) begin
                    dir = (pick < 55) ? psie_pkg::CMD_NEXT : psie_pkg::CMD_PREV;
                    burst = $urandom_range(1, 6);
                    repeat (burst) issue_random_step(dir);
                    done += burst;
                end else if (pick < 82) begin
                    issue_random_step(psie_pkg::CMD_READ);
                    done++;
                end else if (pick < 93) begin
                    issue_random_step(psie_pkg::CMD_COUNT);
                    done++;
                end else begin
                    // ignored codes do not count toward the phase
                    issue_random_step(psie_pkg::CMD_W'($urandom_range(5, 7)));
                end
            end
            no_gaps = 1'b0;
        end
    endtask

    initial begin
        shadow_len = psie_pkg::LEN_W'(psie_pkg::LEN_RESET);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_full_length_wrap();
        test_length_edges();
        test_repeated_values();
        test_random_traffic(154);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d commands sent, %0d results checked, %0d steps wrapped, %0d counts",
                 commands_sent, results_seen, wraps_seen, counts_seen);
        $display("lengths 0, 1, 2, 3, 4, 5, 16 and 31 exercised, %0d errors", error_count);
        if (error_count == 0) begin
            $display("[permutation_step_inversion_engine] OK");
        end else begin
            $display("[permutation_step_inversion_engine] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
sv/psie_pkg.sv
sv/psie_ram.sv
sv/psie_dp.sv
sv/psie_ctrl.sv
sv/permutation_step_inversion_engine.sv
test/tb_permutation_step_inversion_engine.sv
